/* rtl/line_pixel_rasterizer_assert.svh */
// ----------------------------------------------------------------------------
// Line pixel rasterizer: assertion macros
// Shorthand for clocked assertions on clk with rst_n as the disable.
// ----------------------------------------------------------------------------
`ifndef LINE_PIXEL_RASTERIZER_ASSERT_SVH
`define LINE_PIXEL_RASTERIZER_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define LPR_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("line_pixel_rasterizer assertion failed");

// consequent checked in the cycle after the antecedent
`define LPR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("line_pixel_rasterizer assertion failed");

`endif

/* rtl/lpr_pkg.sv */
// ----------------------------------------------------------------------------
// lpr_pkg
// Shared constants and types of the line pixel rasterizer.
// ----------------------------------------------------------------------------
package lpr_pkg;

  localparam int COORD_BITS_DEF = 13;

  // screen size registers
  localparam int CFG_W      = 13;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;

  localparam logic [CFG_W-1:0] SCREEN_W_RST = 13'd320;
  localparam logic [CFG_W-1:0] SCREEN_H_RST = 13'd240;

  // register index, taken from paddr[2] (word addressing)
  localparam logic REG_SCREEN_W = 1'b0;
  localparam logic REG_SCREEN_H = 1'b1;

  typedef enum logic {
    REQ_LOAD    = 1'b0,
    REQ_ADVANCE = 1'b1
  } req_type_t;

endpackage

/* rtl/line_pixel_rasterizer.sv */
// ----------------------------------------------------------------------------
// line_pixel_rasterizer
// Integer Bresenham line walk: a load transaction sets up a line from two
// endpoints, each advance transaction emits the next pixel of it.
// ----------------------------------------------------------------------------
//  channel | direction | payload
//  --------+-----------+---------------------------------------------------
//  in_     | slave     | tuser: req_type; tdata: x_start, y_start, x_end, y_end
//  out_    | master    | tdata: pixel_x, pixel_y; tuser: on_screen; tlast
//  cfg_    | APB slave | screen_width @ 0x0, screen_height @ 0x4
//
//  One transaction per cycle while in_tready is high. From input to result:
//  an input register, then the walk step, which writes the line state and
//  the result register in the same cycle.
//  in_tready drops only while the input register holds an advance and the
//  result register is full and stalled.
//  rst_n is synchronous; it ends any active line and restores 320 x 240.
// ----------------------------------------------------------------------------
module line_pixel_rasterizer #(
  parameter int COORD_BITS = lpr_pkg::COORD_BITS_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  // input stream
  input  logic                                    in_tvalid,
  output logic                                    in_tready,
  input  logic [((4*COORD_BITS+7)/8)*8-1:0]       in_tdata,  // x_start, y_start, x_end, y_end
  input  logic                                    in_tuser,  // req_type
  // result stream
  output logic                                    out_tvalid,
  input  logic                                    out_tready,
  output logic [((2*COORD_BITS+7)/8)*8-1:0]       out_tdata, // pixel_x, pixel_y
  output logic                                    out_tuser, // on_screen
  output logic                                    out_tlast, // last_pixel
  // configuration
  input  logic                                    cfg_psel,
  input  logic                                    cfg_penable,
  input  logic                                    cfg_pwrite,
  input  logic [lpr_pkg::CFG_ADDR_W-1:0]          cfg_paddr,
  input  logic [lpr_pkg::CFG_DATA_W-1:0]          cfg_pwdata,
  output logic [lpr_pkg::CFG_DATA_W-1:0]          cfg_prdata,
  output logic                                    cfg_pready
);
  import lpr_pkg::*;

  localparam int CB    = COORD_BITS;
  localparam int DW    = CB + 1;      // deltas and walk counters
  localparam int EW    = DW + 1;      // error term
  localparam int CMP_W = (DW > CFG_W) ? DW : CFG_W;
  localparam int OUT_W = ((2*CB+7)/8)*8;

  // ---------------- configuration ----------------
  logic [CFG_W-1:0] scr_w_r, scr_h_r;
  logic             cfg_wr;
  logic             cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = cfg_paddr[CFG_ADDR_W-1];

  always_comb begin
    unique case (cfg_idx)
      REG_SCREEN_W: cfg_prdata = CFG_DATA_W'(scr_w_r);
      REG_SCREEN_H: cfg_prdata = CFG_DATA_W'(scr_h_r);
      default:      cfg_prdata = '0;
    endcase
  end

  // ---------------- registers ----------------
  logic                 s1_valid_r;
  req_type_t            s1_type_r;
  logic signed [CB-1:0] s1_xa_r, s1_ya_r, s1_xb_r, s1_yb_r;

  logic                 active_r, active_nxt;
  logic signed [CB-1:0] org_x_r, org_x_nxt, org_y_r, org_y_nxt;
  logic [DW-1:0]        maj_cnt_r, maj_cnt_nxt;
  logic [DW-1:0]        maj_len_r, maj_len_nxt;
  logic [DW-1:0]        min_dlt_r, min_dlt_nxt;
  logic [DW-1:0]        min_off_r, min_off_nxt;
  logic signed [EW-1:0] err_r, err_nxt;
  logic                 min_neg_r, min_neg_nxt;
  logic                 steep_r, steep_nxt;

  logic                 out_valid_r;
  logic [CB-1:0]        out_x_r, out_y_r;
  logic                 out_vis_r, out_last_r;

  // ---------------- handshake ----------------
  logic emit, out_free, adv, in_acc;

  assign emit      = (s1_type_r == REQ_ADVANCE) && active_r;
  assign out_free  = !out_valid_r || out_tready;
  assign adv       = s1_valid_r && (!emit || out_free);
  assign in_tready = !s1_valid_r || adv;
  assign in_acc    = in_tvalid && in_tready;

  // ---------------- line setup ----------------
  logic signed [DW-1:0] xa_w, ya_w, xb_w, yb_w, dx, dy, da, db;
  logic [DW-1:0]        adx, ady;
  logic                 ld_steep, ld_neg;

  always_comb begin
    xa_w     = DW'(s1_xa_r);
    ya_w     = DW'(s1_ya_r);
    xb_w     = DW'(s1_xb_r);
    yb_w     = DW'(s1_yb_r);
    dx       = xb_w - xa_w;
    dy       = yb_w - ya_w;
    adx      = dx[DW-1] ? DW'(-dx) : DW'(dx);
    ady      = dy[DW-1] ? DW'(-dy) : DW'(dy);
    ld_steep = ady > adx;          // x wins a tie
    da       = ld_steep ? dy : dx;
    db       = ld_steep ? dx : dy;
    // minor direction after the swap: sign of db flips when da was negative
    ld_neg   = (db != '0) && (db[DW-1] != da[DW-1]);
  end

  // ---------------- walk step ----------------
  logic signed [DW-1:0] off_s, b_w, cnt_s, px, py;
  logic                 last, vis;
  logic [EW-1:0]        err_sub, err_fix;

  always_comb begin
    off_s   = $signed(min_off_r);
    b_w     = min_neg_r ? -off_s : off_s;
    cnt_s   = $signed(maj_cnt_r);
    px      = DW'(org_x_r) + (steep_r ? b_w : cnt_s);
    py      = DW'(org_y_r) + (steep_r ? cnt_s : b_w);
    last    = maj_cnt_r >= maj_len_r;
    vis     = !px[DW-1] && (CMP_W'(px[DW-2:0]) < CMP_W'(scr_w_r)) &&
              !py[DW-1] && (CMP_W'(py[DW-2:0]) < CMP_W'(scr_h_r));
    err_sub = EW'(err_r) - EW'(min_dlt_r);
    err_fix = err_sub + EW'(maj_len_r);
  end

  always_comb begin
    active_nxt  = active_r;
    org_x_nxt   = org_x_r;
    org_y_nxt   = org_y_r;
    maj_cnt_nxt = maj_cnt_r;
    maj_len_nxt = maj_len_r;
    min_dlt_nxt = min_dlt_r;
    min_off_nxt = min_off_r;
    err_nxt     = err_r;
    min_neg_nxt = min_neg_r;
    steep_nxt   = steep_r;
    if (adv && s1_type_r == REQ_LOAD) begin
      active_nxt  = 1'b1;
      org_x_nxt   = da[DW-1] ? s1_xb_r : s1_xa_r;
      org_y_nxt   = da[DW-1] ? s1_yb_r : s1_ya_r;
      maj_cnt_nxt = '0;
      maj_len_nxt = ld_steep ? ady : adx;
      min_dlt_nxt = ld_steep ? adx : ady;
      min_off_nxt = '0;
      err_nxt     = $signed(EW'(maj_len_nxt >> 1));
      min_neg_nxt = ld_neg;
      steep_nxt   = ld_steep;
    end else if (adv && emit) begin
      err_nxt     = $signed(err_sub[EW-1] ? err_fix : err_sub);
      min_off_nxt = min_off_r + DW'(err_sub[EW-1]);
      if (last) begin
        active_nxt  = 1'b0;
      end else begin
        maj_cnt_nxt = maj_cnt_r + DW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scr_w_r     <= SCREEN_W_RST;
      scr_h_r     <= SCREEN_H_RST;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      active_r    <= 1'b0;
      org_x_r     <= '0;
      org_y_r     <= '0;
      maj_cnt_r   <= '0;
      maj_len_r   <= '0;
      min_dlt_r   <= '0;
      min_off_r   <= '0;
      err_r       <= '0;
      min_neg_r   <= 1'b0;
      steep_r     <= 1'b0;
    end else begin
      if (cfg_wr && cfg_idx == REG_SCREEN_W) begin
        scr_w_r <= cfg_pwdata[CFG_W-1:0];
      end
      if (cfg_wr && cfg_idx == REG_SCREEN_H) begin
        scr_h_r <= cfg_pwdata[CFG_W-1:0];
      end

      if (in_acc) begin
        s1_valid_r <= 1'b1;
      end else if (adv) begin
        s1_valid_r <= 1'b0;
      end

      if (adv && emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end

      active_r  <= active_nxt;
      org_x_r   <= org_x_nxt;
      org_y_r   <= org_y_nxt;
      maj_cnt_r <= maj_cnt_nxt;
      maj_len_r <= maj_len_nxt;
      min_dlt_r <= min_dlt_nxt;
      min_off_r <= min_off_nxt;
      err_r     <= err_nxt;
      min_neg_r <= min_neg_nxt;
      steep_r   <= steep_nxt;
    end

    // payload, no reset
    if (in_acc) begin
      s1_type_r <= req_type_t'(in_tuser);
      s1_xa_r   <= in_tdata[0*CB +: CB];
      s1_ya_r   <= in_tdata[1*CB +: CB];
      s1_xb_r   <= in_tdata[2*CB +: CB];
      s1_yb_r   <= in_tdata[3*CB +: CB];
    end
    if (adv && emit) begin
      out_x_r    <= px[CB-1:0];
      out_y_r    <= py[CB-1:0];
      out_vis_r  <= vis;
      out_last_r <= last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_W'({out_y_r, out_x_r});
  assign out_tuser  = out_vis_r;
  assign out_tlast  = out_last_r;

endmodule

/* rtl/lpr_checker.sv */
// ----------------------------------------------------------------------------
// lpr_checker
// Port-level checks on the line pixel rasterizer, bound to the top level.
// ----------------------------------------------------------------------------
`include "line_pixel_rasterizer_assert.svh"

module lpr_checker #(
  parameter int COORD_BITS = lpr_pkg::COORD_BITS_DEF
) (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_tvalid,
  input logic                               in_tready,
  input logic                               in_tuser,  // req_type
  input logic                               out_tvalid,
  input logic                               out_tready,
  input logic [((2*COORD_BITS+7)/8)*8-1:0]  out_tdata, // pixel_x, pixel_y
  input logic                               out_tuser, // on_screen
  input logic                               out_tlast,
  input logic                               cfg_psel,
  input logic                               cfg_penable,
  input logic                               cfg_pwrite,
  input logic [lpr_pkg::CFG_ADDR_W-1:0]     cfg_paddr,
  input logic [lpr_pkg::CFG_DATA_W-1:0]     cfg_pwdata,
  input logic [lpr_pkg::CFG_DATA_W-1:0]     cfg_prdata,
  input logic                               cfg_pready
);
  import lpr_pkg::*;

  logic in_txn, cfg_wr;

  assign in_txn = in_tvalid && in_tready;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  // a stalled result keeps its payload
  `LPR_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tlast) && $stable(out_tuser))

  // a fresh result comes from an advance transaction, by way of the input register and the walk step
  `LPR_ASSERT_NOW(a_out_src, $rose(out_tvalid), $past(in_txn, 2) && ($past(in_tuser, 2) == REQ_ADVANCE))

  // screen width readback right after a write
  `LPR_ASSERT_NOW(a_width_rb, $past(cfg_wr && (cfg_paddr[CFG_ADDR_W-1] == REG_SCREEN_W)) && cfg_psel && !cfg_pwrite && (cfg_paddr[CFG_ADDR_W-1] == REG_SCREEN_W), cfg_prdata[CFG_W-1:0] == $past(cfg_pwdata[CFG_W-1:0]))

  // screen height readback right after a write
  `LPR_ASSERT_NOW(a_height_rb, $past(cfg_wr && (cfg_paddr[CFG_ADDR_W-1] == REG_SCREEN_H)) && cfg_psel && !cfg_pwrite && (cfg_paddr[CFG_ADDR_W-1] == REG_SCREEN_H), cfg_prdata[CFG_W-1:0] == $past(cfg_pwdata[CFG_W-1:0]))

endmodule

bind line_pixel_rasterizer lpr_checker #(.COORD_BITS(COORD_BITS)) u_lpr_checker (.*);
